>>> rtl/fsc_pkg.sv
// fsc_pkg: shared types and constants for the falling sand cell update block
// no dependencies; imported by the interfaces, the modules and the checker

package fsc_pkg;

   localparam int KIND_W     = 2;
   localparam int COORD_W    = 7;
   localparam int POS_W      = 8;
   localparam int FALL_W     = 3;
   localparam int SPREAD_W   = 4;
   localparam int OPCODE_W   = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd0;
   localparam logic [KIND_W-1:0] KIND_SAND  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_WATER = 2'd2;

   localparam logic [OPCODE_W-1:0] OP_WRITE  = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_READ   = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_UPDATE = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FALL   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPREAD = 2'd3;

   localparam logic [7:0]          WIDTH_RESET  = 8'd128;
   localparam logic [7:0]          HEIGHT_RESET = 8'd128;
   localparam logic [FALL_W-1:0]   FALL_RESET   = 3'd3;
   localparam logic [SPREAD_W-1:0] SPREAD_RESET = 4'd5;

   typedef enum logic [1:0] {
      DIR_DOWN,
      DIR_RIGHT,
      DIR_LEFT
   } dir_type;

   typedef struct packed {
      logic [POS_W-1:0]    use_w;
      logic [POS_W-1:0]    use_h;
      logic [FALL_W-1:0]   fall;
      logic [SPREAD_W-1:0] spread;
   } cfg_type;

endpackage

>>> rtl/fsc_if.sv
// fsc_if: valid/ready channel interfaces for command and result beats
// depends on fsc_pkg

interface fsc_req_if import fsc_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [OPCODE_W-1:0] opcode;
   logic [COORD_W-1:0]  col;
   logic [COORD_W-1:0]  row;
   logic [KIND_W-1:0]   cell_kind;

   modport source (output valid, output opcode, output col, output row, output cell_kind,
                   input ready);
   modport sink   (input valid, input opcode, input col, input row, input cell_kind,
                   output ready);
endinterface

interface fsc_rsp_if import fsc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [KIND_W-1:0]  found_kind;
   logic               moved;
   logic [COORD_W-1:0] final_col;
   logic [COORD_W-1:0] final_row;

   modport source (output valid, output found_kind, output moved, output final_col,
                   output final_row, input ready);
   modport sink   (input valid, input found_kind, input moved, input final_col,
                   input final_row, output ready);
endinterface

>>> rtl/fsc_csr.sv
// fsc_csr: configuration registers and the clipped grid extent in use
// depends on fsc_pkg

module fsc_csr import fsc_pkg::*; #(
   parameter int GRID_COLS = 128,
   parameter int GRID_ROWS = 128
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   logic [7:0]          width_ff,  width_in;
   logic [7:0]          height_ff, height_in;
   logic [FALL_W-1:0]   fall_ff,   fall_in;
   logic [SPREAD_W-1:0] spread_ff, spread_in;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      fall_in   = fall_ff;
      spread_in = spread_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_WIDTH:  width_in  = csr_wdata;
            CSR_HEIGHT: height_in = csr_wdata;
            CSR_FALL:   fall_in   = csr_wdata[FALL_W-1:0];
            CSR_SPREAD: spread_in = csr_wdata[SPREAD_W-1:0];
            default:    width_in  = width_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         fall_ff   <= FALL_RESET;
         spread_ff <= SPREAD_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         fall_ff   <= fall_in;
         spread_ff <= spread_in;
      end
   end

   // extent in use is the register clipped to the physical grid
   assign cfg.use_w  = (int'(width_ff) < GRID_COLS) ? width_ff : POS_W'(GRID_COLS);
   assign cfg.use_h  = (int'(height_ff) < GRID_ROWS) ? height_ff : POS_W'(GRID_ROWS);
   assign cfg.fall   = fall_ff;
   assign cfg.spread = spread_ff;

endmodule

>>> rtl/fsc_grid_mem.sv
// fsc_grid_mem: single-port-write, single-port-read cell store, 2 bits per cell
// read data is registered; depends on fsc_pkg

module fsc_grid_mem import fsc_pkg::*; #(
   parameter int DEPTH = 16384,
   parameter int AW    = 14
) (
   input  logic              clock,
   input  logic              rd_en,
   input  logic [AW-1:0]     rd_addr,
   output logic [KIND_W-1:0] rd_data,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  logic [KIND_W-1:0] wr_data
);

   logic [KIND_W-1:0] mem [DEPTH];
   logic [KIND_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/fsc_seq.sv
// fsc_seq: command sequencer; reads the cell, probes neighbours for an update, then
// writes destination and origin of a move, or the written cell; depends on fsc_pkg, fsc_if

module fsc_seq import fsc_pkg::*; #(
   parameter int GRID_COLS = 128,
   parameter int DEPTH     = 16384,
   parameter int AW        = 14
) (
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   fsc_req_if.sink           req_ch,
   fsc_rsp_if.source         rsp_ch,
   output logic              mem_rd_en,
   output logic [AW-1:0]     mem_rd_addr,
   input  logic [KIND_W-1:0] mem_rd_data,
   output logic              mem_wr_en,
   output logic [AW-1:0]     mem_wr_addr,
   output logic [KIND_W-1:0] mem_wr_data
);

   typedef enum logic [12:0] {
      S_CLEAR    = 13'b0000000000001,
      S_IDLE     = 13'b0000000000010,
      S_HOME     = 13'b0000000000100,
      S_BELOW    = 13'b0000000001000,
      S_DIAG_R   = 13'b0000000010000,
      S_DIAG_L   = 13'b0000000100000,
      S_SIDE_R   = 13'b0000001000000,
      S_SIDE_L   = 13'b0000010000000,
      S_SLIDE_GO = 13'b0000100000000,
      S_SLIDE    = 13'b0001000000000,
      S_WR_DEST  = 13'b0010000000000,
      S_WR_ORIG  = 13'b0100000000000,
      S_DONE     = 13'b1000000000000
   } state_type;

   state_type           state_ff, state_in;
   logic [AW-1:0]       clr_ff, clr_in;
   logic [OPCODE_W-1:0] op_ff, op_in;
   logic [POS_W-1:0]    c_ff, c_in;
   logic [POS_W-1:0]    r_ff, r_in;
   logic [KIND_W-1:0]   kind_ff, kind_in;
   logic [KIND_W-1:0]   found_ff, found_in;
   logic                below_water_ff, below_water_in;
   logic                probe_ok_ff, probe_ok_in;
   logic [POS_W-1:0]    pc_ff, pc_in;
   logic [POS_W-1:0]    pr_ff, pr_in;
   logic [SPREAD_W-1:0] n_ff, n_in;
   logic [SPREAD_W-1:0] lim_ff, lim_in;
   dir_type             dir_ff, dir_in;
   logic                moved_ff, moved_in;
   logic [KIND_W-1:0]   mv_kind_ff, mv_kind_in;
   logic [KIND_W-1:0]   orig_kind_ff, orig_kind_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]   rsp_found_ff, rsp_found_in;
   logic                rsp_moved_ff, rsp_moved_in;
   logic [COORD_W-1:0]  rsp_col_ff, rsp_col_in;
   logic [COORD_W-1:0]  rsp_row_ff, rsp_row_in;

   logic [POS_W-1:0]    tc, tr;
   logic                t_ok;
   logic [POS_W-1:0]    wc, wr;
   logic                free;
   logic [POS_W-1:0]    sc, sr;
   logic                s_ok;

   assign free = probe_ok_ff && (mem_rd_data == KIND_EMPTY);

   // next cell along the current slide direction
   always_comb begin
      sc   = pc_ff;
      sr   = pr_ff;
      s_ok = (n_ff != lim_ff);
      case (dir_ff)
         DIR_DOWN:  sr = pr_ff + 8'd1;
         DIR_RIGHT: sc = pc_ff + 8'd1;
         DIR_LEFT: begin
            sc   = pc_ff - 8'd1;
            s_ok = s_ok && (pc_ff != '0);
         end
         default:   s_ok = 1'b0;
      endcase
      s_ok = s_ok && (sc < cfg.use_w) && (sr < cfg.use_h);
   end

   always_comb begin
      logic                sl_go;
      logic [POS_W-1:0]    sl_c;
      logic [POS_W-1:0]    sl_r;
      dir_type             sl_dir;
      logic [SPREAD_W-1:0] sl_lim;
      logic [POS_W-1:0]    c_p1;
      logic [POS_W-1:0]    c_m1;
      logic [POS_W-1:0]    r_p1;
      logic                in_area;

      sl_go   = 1'b0;
      sl_c    = c_ff;
      sl_r    = r_ff;
      sl_dir  = DIR_DOWN;
      sl_lim  = '0;
      c_p1    = c_ff + 8'd1;
      c_m1    = c_ff - 8'd1;
      r_p1    = r_ff + 8'd1;
      in_area = ({1'b0, req_ch.col} < cfg.use_w) && ({1'b0, req_ch.row} < cfg.use_h);

      state_in       = state_ff;
      clr_in         = clr_ff;
      op_in          = op_ff;
      c_in           = c_ff;
      r_in           = r_ff;
      kind_in        = kind_ff;
      found_in       = found_ff;
      below_water_in = below_water_ff;
      probe_ok_in    = probe_ok_ff;
      pc_in          = pc_ff;
      pr_in          = pr_ff;
      n_in           = n_ff;
      lim_in         = lim_ff;
      dir_in         = dir_ff;
      moved_in       = moved_ff;
      mv_kind_in     = mv_kind_ff;
      orig_kind_in   = orig_kind_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      rsp_found_in   = rsp_found_ff;
      rsp_moved_in   = rsp_moved_ff;
      rsp_col_in     = rsp_col_ff;
      rsp_row_in     = rsp_row_ff;

      tc        = c_ff;
      tr        = r_ff;
      t_ok      = 1'b0;
      mem_rd_en = 1'b0;
      mem_wr_en = 1'b0;
      wc        = c_ff;
      wr        = r_ff;
      mem_wr_data = KIND_EMPTY;

      case (state_ff)
         S_CLEAR: begin
            mem_wr_en = 1'b1;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == AW'(DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_ch.valid) begin
               op_in    = req_ch.opcode;
               c_in     = {1'b0, req_ch.col};
               r_in     = {1'b0, req_ch.row};
               kind_in  = req_ch.cell_kind;
               pc_in    = {1'b0, req_ch.col};
               pr_in    = {1'b0, req_ch.row};
               found_in = KIND_EMPTY;
               moved_in = 1'b0;
               tc       = {1'b0, req_ch.col};
               tr       = {1'b0, req_ch.row};
               t_ok     = in_area;
               state_in = in_area ? S_HOME : S_DONE;
            end
         end
         S_HOME: begin
            found_in = mem_rd_data;
            case (op_ff)
               OP_WRITE: begin
                  orig_kind_in = (kind_ff == KIND_SAND || kind_ff == KIND_WATER) ?
                                 kind_ff : KIND_EMPTY;
                  state_in     = S_WR_ORIG;
               end
               OP_UPDATE: begin
                  if (mem_rd_data == KIND_SAND || mem_rd_data == KIND_WATER) begin
                     tc       = c_ff;
                     tr       = r_p1;
                     t_ok     = r_p1 < cfg.use_h;
                     state_in = S_BELOW;
                  end else begin
                     state_in = S_DONE;
                  end
               end
               OP_READ:  state_in = S_DONE;
               default:  state_in = S_DONE;
            endcase
         end
         S_BELOW: begin
            below_water_in = probe_ok_ff && (mem_rd_data == KIND_WATER);
            if (free) begin
               sl_go  = 1'b1;
               sl_c   = c_ff;
               sl_r   = r_p1;
               sl_dir = DIR_DOWN;
               sl_lim = {1'b0, cfg.fall};
            end else if (found_ff == KIND_SAND) begin
               tc       = c_p1;
               tr       = r_p1;
               t_ok     = (c_p1 < cfg.use_w) && (r_p1 < cfg.use_h);
               state_in = S_DIAG_R;
            end else begin
               tc       = c_p1;
               tr       = r_ff;
               t_ok     = c_p1 < cfg.use_w;
               state_in = S_SIDE_R;
            end
         end
         S_DIAG_R: begin
            if (free) begin
               pc_in        = c_p1;
               pr_in        = r_p1;
               moved_in     = 1'b1;
               mv_kind_in   = KIND_SAND;
               orig_kind_in = KIND_EMPTY;
               state_in     = S_WR_DEST;
            end else begin
               tc       = c_m1;
               tr       = r_p1;
               t_ok     = (c_ff != '0) && (r_p1 < cfg.use_h);
               state_in = S_DIAG_L;
            end
         end
         S_DIAG_L: begin
            if (free) begin
               pc_in        = c_m1;
               pr_in        = r_p1;
               moved_in     = 1'b1;
               mv_kind_in   = KIND_SAND;
               orig_kind_in = KIND_EMPTY;
               state_in     = S_WR_DEST;
            end else if (below_water_ff) begin
               // sand sinks, water rises into the vacated cell
               pc_in        = c_ff;
               pr_in        = r_p1;
               moved_in     = 1'b1;
               mv_kind_in   = KIND_SAND;
               orig_kind_in = KIND_WATER;
               state_in     = S_WR_DEST;
            end else begin
               state_in = S_DONE;
            end
         end
         S_SIDE_R: begin
            if (free) begin
               sl_go  = 1'b1;
               sl_c   = c_p1;
               sl_r   = r_ff;
               sl_dir = DIR_RIGHT;
               sl_lim = cfg.spread;
            end else begin
               tc       = c_m1;
               tr       = r_ff;
               t_ok     = c_ff != '0;
               state_in = S_SIDE_L;
            end
         end
         S_SIDE_L: begin
            if (free) begin
               sl_go  = 1'b1;
               sl_c   = c_m1;
               sl_r   = r_ff;
               sl_dir = DIR_LEFT;
               sl_lim = cfg.spread;
            end else begin
               state_in = S_DONE;
            end
         end
         S_SLIDE_GO: begin
            if (s_ok) begin
               tc       = sc;
               tr       = sr;
               t_ok     = 1'b1;
               state_in = S_SLIDE;
            end else begin
               state_in = S_WR_DEST;
            end
         end
         S_SLIDE: begin
            if (mem_rd_data == KIND_EMPTY) begin
               pc_in    = sc;
               pr_in    = sr;
               n_in     = n_ff + 1'b1;
               state_in = S_SLIDE_GO;
            end else begin
               state_in = S_WR_DEST;
            end
         end
         S_WR_DEST: begin
            mem_wr_en   = 1'b1;
            wc          = pc_ff;
            wr          = pr_ff;
            mem_wr_data = mv_kind_ff;
            state_in    = S_WR_ORIG;
         end
         S_WR_ORIG: begin
            mem_wr_en   = 1'b1;
            mem_wr_data = orig_kind_ff;
            state_in    = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = found_ff;
               rsp_moved_in = moved_ff;
               rsp_col_in   = pc_ff[COORD_W-1:0];
               rsp_row_in   = pr_ff[COORD_W-1:0];
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // first step of a slide is already known free
      if (sl_go) begin
         if (sl_lim == '0) begin
            state_in = S_DONE;
         end else begin
            pc_in        = sl_c;
            pr_in        = sl_r;
            n_in         = SPREAD_W'(1);
            lim_in       = sl_lim;
            dir_in       = sl_dir;
            moved_in     = 1'b1;
            mv_kind_in   = found_ff;
            orig_kind_in = KIND_EMPTY;
            state_in     = S_SLIDE_GO;
         end
      end

      probe_ok_in = t_ok;
      mem_rd_en   = t_ok;
   end

   assign mem_rd_addr = AW'(tr) * AW'(GRID_COLS) + AW'(tc);
   assign mem_wr_addr = (state_ff == S_CLEAR) ? clr_ff : AW'(wr) * AW'(GRID_COLS) + AW'(wc);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      c_ff           <= c_in;
      r_ff           <= r_in;
      kind_ff        <= kind_in;
      found_ff       <= found_in;
      below_water_ff <= below_water_in;
      probe_ok_ff    <= probe_ok_in;
      pc_ff          <= pc_in;
      pr_ff          <= pr_in;
      n_ff           <= n_in;
      lim_ff         <= lim_in;
      dir_ff         <= dir_in;
      moved_ff       <= moved_in;
      mv_kind_ff     <= mv_kind_in;
      orig_kind_ff   <= orig_kind_in;
      rsp_found_ff   <= rsp_found_in;
      rsp_moved_ff   <= rsp_moved_in;
      rsp_col_ff     <= rsp_col_in;
      rsp_row_ff     <= rsp_row_in;
   end

   assign req_ch.ready      = (state_ff == S_IDLE);
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.found_kind = rsp_found_ff;
   assign rsp_ch.moved      = rsp_moved_ff;
   assign rsp_ch.final_col  = rsp_col_ff;
   assign rsp_ch.final_row  = rsp_row_ff;

endmodule

>>> rtl/falling_sand_cell_update.sv
// falling_sand_cell_update: top level of the falling sand cell update block
// depends on fsc_pkg, fsc_if, fsc_csr, fsc_grid_mem, fsc_seq
//
// req_ch carries one command beat: write a cell, read a cell, or update the
// particle at a cell. rsp_ch returns exactly one beat per command, in order:
// the kind found, whether the particle moved and where it ended.
// csr_* writes the extent in use and the fall and spread limits; write only
// while no command is in flight.
// Each command inside the extent reads the addressed cell; an update of sand or
// water then probes neighbours one at a time through the single read port of
// the grid memory, and a write or a move then writes back. A command outside
// the extent goes straight to its result. A slide probes each further cell in
// turn until it meets an occupied cell, the edge of the extent or its limit.
// A new command is accepted only once the last one has put its result in the
// output register.
// After reset the whole grid memory is swept to empty, one cell per cycle;
// req_ch.ready stays low meanwhile.
// A stalled result waits in the output register; the next command is still
// accepted and runs up to its result, which then waits for the register.

module falling_sand_cell_update import fsc_pkg::*; #(
   parameter int GRID_COLS = 128,
   parameter int GRID_ROWS = 128
) (
   input  logic                  clock,
   input  logic                  reset,
   fsc_req_if.sink               req_ch,
   fsc_rsp_if.source             rsp_ch,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int DEPTH = GRID_COLS * GRID_ROWS;
   localparam int AW    = $clog2(DEPTH);

   cfg_type           cfg;
   logic              mem_rd_en;
   logic [AW-1:0]     mem_rd_addr;
   logic [KIND_W-1:0] mem_rd_data;
   logic              mem_wr_en;
   logic [AW-1:0]     mem_wr_addr;
   logic [KIND_W-1:0] mem_wr_data;

   fsc_csr #(
      .GRID_COLS (GRID_COLS),
      .GRID_ROWS (GRID_ROWS)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   fsc_grid_mem #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_grid_mem (
      .clock   (clock),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data)
   );

   fsc_seq #(
      .GRID_COLS (GRID_COLS),
      .DEPTH     (DEPTH),
      .AW        (AW)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data)
   );

endmodule

>>> rtl/fsc_checker.sv
// fsc_checker: port-level checks on the falling sand cell update block
// depends on fsc_pkg; bound to falling_sand_cell_update below

module fsc_checker import fsc_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [KIND_W-1:0]  rsp_found_kind,
   input logic               rsp_moved,
   input logic [COORD_W-1:0] rsp_final_col,
   input logic [COORD_W-1:0] rsp_final_row
);

   logic [1:0] pending_ff, pending_in;

   // commands taken but whose result beat is not yet delivered
   always_comb begin
      pending_in = pending_ff;
      if ((req_valid && req_ready) && !(rsp_valid && rsp_ready)) begin
         pending_in = pending_ff + 2'd1;
      end else if (!(req_valid && req_ready) && (rsp_valid && rsp_ready)) begin
         pending_in = pending_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_no_ready_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("command accepted during grid clear");

   a_rsp_has_cmd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 2'd0)
      else $error("result beat without a pending command");

   a_pending_bound: assert property (@(posedge clock) disable iff (reset)
      pending_ff != 2'd3)
      else $error("more than two commands in flight");

   a_moved_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_moved |-> rsp_found_kind == KIND_SAND || rsp_found_kind == KIND_WATER)
      else $error("movement reported for an empty cell");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_found_kind) && $stable(rsp_moved)
         && $stable(rsp_final_col) && $stable(rsp_final_row))
      else $error("stalled result beat changed");

endmodule

bind falling_sand_cell_update fsc_checker u_fsc_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_ch.valid),
   .req_ready      (req_ch.ready),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_found_kind (rsp_ch.found_kind),
   .rsp_moved      (rsp_ch.moved),
   .rsp_final_col  (rsp_ch.final_col),
   .rsp_final_row  (rsp_ch.final_row)
);
